>>> rtl/core/its_pkg.sv
package its_pkg;

  // Epoch seconds width (signed)
  localparam int EPOCH_W = 39;

  // Default depth of the record queue between parser and converter
  localparam int QUEUE_DEPTH = 2;

  // One parsed timestamp, handed from parser to converter
  typedef struct packed {
    logic        ok;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } rec_t;

endpackage

>>> rtl/core/iso_timestamp_to_epoch_seconds.sv
// Each record steps through converter states ERA, YOE, DOE, DAYS, MUL and SUM in order.
// Throughput: one character per cycle while s_tready is high; the converter takes one
// string at a time, so strings that arrive faster back up through the record queue
// and pause s_tready.
// Reset: rst is synchronous, active high; it clears the parser, queue and output valid.
module iso_timestamp_to_epoch_seconds #(
  parameter int QUEUE_DEPTH = its_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // is_final
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [38:0] unix_secs, [39] zero
  output logic        m_tuser    // valid_res
);
  import its_pkg::*;

  rec_t                      front_rec, queue_rec;
  logic                      push, pop, q_not_empty, q_not_full;
  logic                      accept;
  logic                      out_ok;
  logic signed [EPOCH_W-1:0] out_epoch;

  assign s_tready = q_not_full;
  assign accept   = s_tvalid && s_tready;

  its_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_code (s_tdata),
    .is_final  (s_tlast),
    .accept    (accept),
    .push      (push),
    .rec       (front_rec)
  );

  its_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_rec    (front_rec),
    .pop       (pop),
    .rd_rec    (queue_rec),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  its_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_not_empty),
    .rec       (queue_rec),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ok    (out_ok),
    .out_epoch (out_epoch)
  );

  assign m_tdata = {1'b0, out_epoch};
  assign m_tuser = out_ok;

endmodule

>>> rtl/core/its_front.sv
module its_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      char_code,
  input  logic            is_final,
  input  logic            accept,
  output logic            push,
  output its_pkg::rec_t   rec
);
  import its_pkg::*;

  localparam logic [4:0] TS_LEN  = 5'd20;
  localparam logic [4:0] POS_SAT = 5'd21;

  logic [4:0]  pos, pos_next;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next;
  logic [6:0]  day, day_next;
  logic [6:0]  hour, hour_next;
  logic [6:0]  minute, minute_next;
  logic [6:0]  second, second_next;
  logic        format_error, format_error_next;
  logic [7:0]  sep;
  logic        is_digit;
  logic [3:0]  dv;
  logic        ok;

  // Separator expected at a position, zero for digit positions
  function automatic logic [7:0] sep_at(input logic [4:0] p);
    logic [7:0] s;
    unique case (p)
      5'd4, 5'd7:   s = 8'h2D;  // '-'
      5'd10:        s = 8'h54;  // 'T'
      5'd13, 5'd16: s = 8'h3A;  // ':'
      5'd19:        s = 8'h5A;  // 'Z'
      default:      s = 8'h00;
    endcase
    return s;
  endfunction

  assign sep      = sep_at(pos);
  assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
  assign dv       = 4'(char_code - 8'h30);

  // Character check and field accumulation
  always_comb begin
    year_next         = year;
    month_next        = month;
    day_next          = day;
    hour_next         = hour;
    minute_next       = minute;
    second_next       = second;
    format_error_next = format_error;
    if (pos >= TS_LEN) begin
      format_error_next = 1'b1;
    end else if (sep != 8'h00) begin
      if (char_code != sep) format_error_next = 1'b1;
    end else if (!is_digit) begin
      format_error_next = 1'b1;
    end else begin
      priority if (pos < 5'd4)  year_next   = 14'(year * 14'd10 + 14'(dv));
      else if (pos < 5'd7)      month_next  = 7'(month * 7'd10 + 7'(dv));
      else if (pos < 5'd10)     day_next    = 7'(day * 7'd10 + 7'(dv));
      else if (pos < 5'd13)     hour_next   = 7'(hour * 7'd10 + 7'(dv));
      else if (pos < 5'd16)     minute_next = 7'(minute * 7'd10 + 7'(dv));
      else                      second_next = 7'(second * 7'd10 + 7'(dv));
    end
  end

  assign pos_next = (pos == POS_SAT) ? POS_SAT : 5'(pos + 5'd1);

  // Length, format and range check on the final character
  assign ok = (pos_next == TS_LEN) && !format_error_next
           && (month_next >= 7'd1) && (month_next <= 7'd12)
           && (day_next >= 7'd1) && (day_next <= 7'd31)
           && (hour_next <= 7'd23) && (minute_next <= 7'd59)
           && (second_next <= 7'd60);

  assign push       = accept && is_final;
  assign rec.ok     = ok;
  assign rec.year   = year_next;
  assign rec.month  = month_next[3:0];
  assign rec.day    = day_next[4:0];
  assign rec.hour   = hour_next[4:0];
  assign rec.minute = minute_next[5:0];
  assign rec.second = second_next[5:0];

  // Parser state; a final character returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (accept && is_final)) begin
      pos          <= '0;
      year         <= '0;
      month        <= '0;
      day          <= '0;
      hour         <= '0;
      minute       <= '0;
      second       <= '0;
      format_error <= 1'b0;
    end else if (accept) begin
      pos          <= pos_next;
      year         <= year_next;
      month        <= month_next;
      day          <= day_next;
      hour         <= hour_next;
      minute       <= minute_next;
      second       <= second_next;
      format_error <= format_error_next;
    end
  end

endmodule

>>> rtl/core/its_queue.sv
module its_queue #(
  parameter int DEPTH = its_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  its_pkg::rec_t   wr_rec,
  input  logic            pop,
  output its_pkg::rec_t   rd_rec,
  output logic            not_empty,
  output logic            not_full
);
  import its_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  rec_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign not_full  = (count != CNT_W'(DEPTH));
  assign rd_rec    = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_rec;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      if (push && !pop)      count <= CNT_W'(count + 1'b1);
      else if (pop && !push) count <= CNT_W'(count - 1'b1);
    end
  end

endmodule

>>> rtl/core/its_back.sv
module its_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               rec_valid,
  input  its_pkg::rec_t                      rec,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_ok,
  output logic signed [its_pkg::EPOCH_W-1:0] out_epoch
);
  import its_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERA  = 3'd1;
  localparam logic [2:0] ST_YOE  = 3'd2;
  localparam logic [2:0] ST_DOE  = 3'd3;
  localparam logic [2:0] ST_DAYS = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_SUM  = 3'd6;

  logic [2:0] state;

  rec_t r;
  logic signed [14:0]        yr, yr_c;
  logic [3:0]                mshift, mshift_c;
  logic signed [5:0]         era, era_c;
  logic [27:0]               era_prod;
  logic [8:0]                yoe, doy;
  logic signed [15:0]        yoe_c;
  logic [1:0]                hund;
  logic [17:0]               doe;
  logic [16:0]               tod;
  logic signed [22:0]        days;
  logic signed [EPOCH_W-1:0] prod, sum;
  logic                      out_load;

  // Day offset of each shifted month start, March first
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Year shifted to start in March, and its 400-year era by reciprocal
  assign yr_c     = $signed({1'b0, r.year}) - ((r.month <= 4'd2) ? 15'sd1 : 15'sd0);
  assign mshift_c = (r.month > 4'd2) ? 4'(r.month - 4'd3) : 4'(r.month + 4'd9);
  assign era_prod = 28'(yr_c[13:0]) * 28'd10486;
  assign era_c    = yr_c[14] ? -6'sd1 : $signed({1'b0, era_prod[26:22]});

  assign yoe_c = 16'(yr) - 16'(era) * 16'sd400;
  assign hund  = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 : (yoe >= 9'd100) ? 2'd1 : 2'd0;
  assign sum   = prod + $signed({22'd0, tod});

  assign pop      = (state == ST_IDLE) && rec_valid;
  assign out_load = (state == ST_SUM) && (!out_valid || out_ready);

  // Conversion sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: if (rec_valid) state <= ST_ERA;
        ST_ERA:  state <= ST_YOE;
        ST_YOE:  state <= ST_DOE;
        ST_DOE:  state <= ST_DAYS;
        ST_DAYS: state <= ST_MUL;
        ST_MUL:  state <= ST_SUM;
        ST_SUM:  if (out_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers, one step per state
  always_ff @(posedge clk) begin
    if (pop) r <= rec;
    if (state == ST_ERA) begin
      yr     <= yr_c;
      era    <= era_c;
      mshift <= r.ok ? mshift_c : 4'd0;
    end
    if (state == ST_YOE) begin
      yoe <= yoe_c[8:0];
      doy <= 9'(month_start(mshift) + 9'(r.day) - 9'd1);
    end
    if (state == ST_DOE) begin
      doe <= 18'(18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(hund) + 18'(doy));
      tod <= 17'(17'(r.hour) * 17'd3600 + 17'(r.minute) * 17'd60 + 17'(r.second));
    end
    if (state == ST_DAYS) begin
      days <= 23'(era) * 23'sd146097 + $signed({5'd0, doe}) - 23'sd719468;
    end
    if (state == ST_MUL) begin
      prod <= EPOCH_W'(days) * 39'sd86400;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok    <= r.ok;
      out_epoch <= r.ok ? sum : '0;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ok |-> out_epoch == '0)
    else $error("invalid result carries nonzero seconds");

  a_epoch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ok |->
      (out_epoch >= -39'sd62167219200) && (out_epoch <= 39'sd253402300800))
    else $error("epoch seconds out of range");

  a_hold_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM) && out_valid && !out_ready |=> state == ST_SUM)
    else $error("result dropped while output stalled");

  a_load_from_sum: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_SUM)
    else $error("output raised outside final step");
`endif

endmodule

>>> sim/iso_timestamp_to_epoch_seconds_checker.sv
module iso_timestamp_to_epoch_seconds_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  input  logic        m_tuser,
  output int          errors,
  output int          pending
);
  import its_pkg::*;

  localparam int STAMP_LEN = 20;
  localparam int POS_SAT = 21;
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_NINE = "9";

  typedef struct packed {
    logic               valid_res;
    logic [EPOCH_W-1:0] unix_secs;
  } stamp_result_t;

  // Expected conversions, oldest first
  stamp_result_t expected_stamps[$];
  stamp_result_t want;

  // Shadow parser state
  logic [4:0]  char_pos;
  logic [13:0] year_acc;
  logic [6:0]  month_acc;
  logic [6:0]  day_acc;
  logic [6:0]  hour_acc;
  logic [6:0]  minute_acc;
  logic [6:0]  second_acc;
  logic        fmt_err;

  int error_count = 0;

  // Separator expected at a string position, zero for a digit position
  function automatic logic [7:0] separator_at(input logic [4:0] pos);
    unique case (pos)
      5'd4, 5'd7:   return "-";
      5'd10:        return "T";
      5'd13, 5'd16: return ":";
      5'd19:        return "Z";
      default:      return 8'd0;
    endcase
  endfunction

  // Proleptic Gregorian date/time to Unix seconds, floor-era arithmetic
  function automatic logic [EPOCH_W-1:0] seconds_since_epoch(
    input logic [13:0] y, input logic [6:0] mo, input logic [6:0] d,
    input logic [6:0] h, input logic [6:0] mi, input logic [6:0] s
  );
    longint yr, era, yoe, mshift, doy, doe, days, secs;
    yr = longint'(y) - ((mo <= 2) ? 1 : 0);
    era = ((yr >= 0) ? yr : yr - 399) / 400;
    yoe = yr - era * 400;
    mshift = (mo > 2) ? longint'(mo) - 3 : longint'(mo) + 9;
    doy = (153 * mshift + 2) / 5 + longint'(d) - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    secs = days * 86400 + longint'(h) * 3600 + longint'(mi) * 60 + longint'(s);
    return secs[EPOCH_W-1:0];
  endfunction

  task automatic clear_fields();
    char_pos = '0;
    year_acc = '0;
    month_acc = '0;
    day_acc = '0;
    hour_acc = '0;
    minute_acc = '0;
    second_acc = '0;
    fmt_err = 1'b0;
  endtask

  // Absorb one character; on the final one queue the expected result
  task automatic parse_char(input logic [7:0] code, input logic fin);
    logic [7:0]    sep;
    logic [6:0]    digit;
    logic          ok;
    stamp_result_t res;
    if (char_pos >= STAMP_LEN) begin
      fmt_err = 1'b1;
    end else begin
      sep = separator_at(char_pos);
      if (sep != 8'd0) begin
        if (code != sep) fmt_err = 1'b1;
      end else if (code < CH_ZERO || code > CH_NINE) begin
        fmt_err = 1'b1;
      end else begin
        digit = 7'(code - CH_ZERO);
        if (char_pos < 4)       year_acc = 14'(year_acc * 14'd10 + 14'(digit));
        else if (char_pos < 7)  month_acc = 7'(month_acc * 7'd10 + digit);
        else if (char_pos < 10) day_acc = 7'(day_acc * 7'd10 + digit);
        else if (char_pos < 13) hour_acc = 7'(hour_acc * 7'd10 + digit);
        else if (char_pos < 16) minute_acc = 7'(minute_acc * 7'd10 + digit);
        else                    second_acc = 7'(second_acc * 7'd10 + digit);
      end
    end
    if (char_pos < POS_SAT) char_pos = 5'(char_pos + 5'd1);

    if (fin) begin
      ok = (char_pos == STAMP_LEN) && !fmt_err
        && month_acc >= 1 && month_acc <= 12
        && day_acc >= 1 && day_acc <= 31
        && hour_acc <= 23 && minute_acc <= 59 && second_acc <= 60;
      res.valid_res = ok;
      res.unix_secs = ok ? seconds_since_epoch(year_acc, month_acc, day_acc,
                                               hour_acc, minute_acc, second_acc)
                         : '0;
      expected_stamps.push_back(res);
      clear_fields();
    end
  endtask

  // Sample both channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      clear_fields();
      expected_stamps.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_stamps.size() == 0) begin
          $error("unexpected result: valid_res=%0d unix_secs=%0d",
                 m_tuser, $signed(m_tdata[EPOCH_W-1:0]));
          error_count++;
        end else begin
          want = expected_stamps.pop_front();
          if (m_tuser !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, m_tuser);
            error_count++;
          end
          if (m_tdata[EPOCH_W-1:0] !== want.unix_secs) begin
            $error("unix_secs: expected %0d, got %0d",
                   $signed(want.unix_secs), $signed(m_tdata[EPOCH_W-1:0]));
            error_count++;
          end
          if (m_tdata[39] !== 1'b0) begin
            $error("tdata pad bit: expected 0, got %0d", m_tdata[39]);
            error_count++;
          end
        end
      end
      if (s_tvalid && s_tready) parse_char(s_tdata, s_tlast);
    end
    errors = error_count;
    pending = expected_stamps.size();
  end

endmodule

>>> sim/iso_timestamp_to_epoch_seconds_tb.sv
module iso_timestamp_to_epoch_seconds_tb;

  localparam int STAMP_LEN = 20;
  localparam int RANDOM_CHARS = 750;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;

  int mismatches;
  int outstanding;

  // Character buffer for the string being sent
  logic [7:0] stamp [0:31];
  int         chars_sent = 0;
  bit         sender_gaps = 1'b0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  always #10 clk = ~clk;

  iso_timestamp_to_epoch_seconds DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  iso_timestamp_to_epoch_seconds_checker stamp_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (mismatches),
    .pending  (outstanding)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Field value biased toward its range ends, sometimes out of range
  function automatic int pick_field(input int lo, input int hi, input int cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return lo;
    if (r < 30) return hi;
    if (r < 38) begin
      if (lo > 0 && $urandom_range(0, 1) == 1) return 0;
      return (hi < cap) ? $urandom_range(hi + 1, cap) : hi;
    end
    return $urandom_range(lo, hi);
  endfunction

  // Characters that tend to break the format
  function automatic logic [7:0] odd_char();
    unique case ($urandom_range(0, 7))
      0:       return "+";
      1:       return "-";
      2:       return " ";
      3:       return ":";
      4:       return "/";
      5:       return 8'(8'h30 + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_num(input int value, input int digits, input int start);
    int v;
    v = value;
    for (int k = digits - 1; k >= 0; k--) begin
      stamp[start + k] = 8'(8'h30 + (v % 10));
      v = v / 10;
    end
  endtask

  task automatic build_stamp(input int y, input int mo, input int d,
                             input int h, input int mi, input int s);
    put_num(y, 4, 0);
    stamp[4] = "-";
    put_num(mo, 2, 5);
    stamp[7] = "-";
    put_num(d, 2, 8);
    stamp[10] = "T";
    put_num(h, 2, 11);
    stamp[13] = ":";
    put_num(mi, 2, 14);
    stamp[16] = ":";
    put_num(s, 2, 17);
    stamp[19] = "Z";
  endtask

  // One request per character, held until accepted
  task automatic send_char(input logic [7:0] code, input logic fin);
    int gap;
    if (sender_gaps) begin
      gap = pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= code;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_stamp(input int len);
    sender_gaps = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < len; i++) send_char(stamp[i], i == len - 1);
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    int kind;
    int extra;
    int n;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // final mark on the very first character
    stamp[0] = "2";
    send_stamp(1);
    // short string with sign and leading space
    stamp[0] = " ";
    stamp[1] = "+";
    stamp[2] = "1";
    send_stamp(3);
    // lowest valid timestamp, year zero
    build_stamp(0, 1, 1, 0, 0, 0);
    send_stamp(STAMP_LEN);

    // output held off while a burst of tiny strings piles up
    hold_req = 1'b1;
    repeat (12) begin
      stamp[0] = 8'($urandom_range(0, 255));
      stamp[1] = "Z";
      sender_gaps = 1'b0;
      n = $urandom_range(1, 2);
      for (int i = 0; i < n; i++) send_char(stamp[i], i == n - 1);
    end

    // random strings, mostly well-formed
    while (chars_sent < RANDOM_CHARS) begin
      kind = $urandom_range(0, 99);
      build_stamp(pick_field(0, 9999, 9999), pick_field(1, 12, 99),
                  pick_field(1, 31, 99), pick_field(0, 23, 99),
                  pick_field(0, 59, 99), pick_field(0, 60, 99));
      if (kind < 65) begin
        send_stamp(STAMP_LEN);
      end else if (kind < 75) begin
        stamp[$urandom_range(0, STAMP_LEN - 1)] = odd_char();
        send_stamp(STAMP_LEN);
      end else if (kind < 83) begin
        send_stamp($urandom_range(1, STAMP_LEN - 1));
      end else if (kind < 91) begin
        extra = $urandom_range(1, 6);
        for (int i = 0; i < extra; i++) stamp[STAMP_LEN + i] = odd_char();
        send_stamp(STAMP_LEN + extra);
      end else begin
        extra = $urandom_range(1, 24);
        for (int i = 0; i < extra; i++) stamp[i] = 8'($urandom_range(0, 255));
        send_stamp(extra);
      end
    end
    s_tvalid <= 1'b0;

    // let the checker absorb the last request before polling its count
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** iso_timestamp_to_epoch_seconds: PASSED **");
    end else begin
      $display("** iso_timestamp_to_epoch_seconds: FAILED **");
    end
    $finish;
  end

  // Result side: random back-pressure, quiet stretches, one long hold-off
  initial begin : receiver
    int r;
    int free_run;
    free_run = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (free_run > 0) begin
        m_tready <= 1'b1;
        free_run--;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          free_run = $urandom_range(30, 80);
        end else if (r < 65) begin
          m_tready <= 1'b1;
          @(posedge clk);
        end else begin
          m_tready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  // Ends the run when nothing moves for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("** iso_timestamp_to_epoch_seconds: FAILED **");
    $finish;
  end

endmodule
